// File: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared widths, command codes, character codes and the cursor step result
// for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int CMD_W   = 3;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int POS_W   = 11;
  localparam int CELL_W  = CHAR_W + COLOR_W;
  localparam int LIN_W   = ROW_W + COL_W;

  // input tdata: command, char_code, color, col, row (from bit 0)
  localparam int IN_FIELDS_W = CMD_W + CHAR_W + COLOR_W + COL_W + ROW_W;
  localparam int IN_W        = ((IN_FIELDS_W + 7) / 8) * 8;
  // output tdata: caret_col, caret_row, cursor_position, cell_char,
  // cell_color, scrolled (from bit 0)
  localparam int OUT_W       = COL_W + ROW_W + POS_W + CHAR_W + COLOR_W + 1;

  localparam logic [CMD_W-1:0] CMD_PUT     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUT_AT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BACK    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_CUR = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd5;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
  localparam int                TAB_STOP   = 4;

  localparam logic [COLOR_W-1:0] DEFAULT_COLOR_RST = 8'd15;

  typedef struct packed {
    logic [COL_W-1:0] col;       // cursor after the item
    logic [ROW_W-1:0] row;
    logic             wr_en;     // one cell write
    logic             wr_blank;  // write a blank instead of the character
    logic [COL_W-1:0] wr_col;    // logical cell to write
    logic [ROW_W-1:0] wr_row;
    logic             scroll;    // screen moves up one row
  } step_res_t;

endpackage

// File: rtl/tcw_cursor_step.sv
// ----------------------------------------------------------------------------
// tcw_cursor_step
// Cursor arithmetic for one command: next cursor, the cell to write and
// whether the screen scrolls.
// ----------------------------------------------------------------------------
module tcw_cursor_step import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic [CMD_W-1:0]  cmd,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [COL_W-1:0]  cur_col,
  input  logic [ROW_W-1:0]  cur_row,
  input  logic [COL_W-1:0]  item_col,   // already saturated
  input  logic [ROW_W-1:0]  item_row,
  output step_res_t         res
);

  always_comb begin
    logic [COL_W-1:0] bc;
    logic [ROW_W-1:0] br;
    logic [COL_W:0]   nc;
    logic [ROW_W:0]   nr;
    logic [COL_W:0]   tab_sum;

    res          = '0;
    res.col      = cur_col;
    res.row      = cur_row;
    res.wr_col   = cur_col;
    res.wr_row   = cur_row;
    bc           = (cmd == CMD_PUT_AT) ? item_col : cur_col;
    br           = (cmd == CMD_PUT_AT) ? item_row : cur_row;
    nc           = {1'b0, bc};
    nr           = {1'b0, br};
    tab_sum      = {1'b0, bc} + (COL_W+1)'(TAB_STOP);

    case (cmd)
      CMD_PUT, CMD_PUT_AT: begin
        res.wr_col = bc;
        res.wr_row = br;
        if (char_code == CH_NEWLINE) begin
          nc = '0;
          nr = {1'b0, br} + 1'b1;
        end else if (char_code == CH_RETURN) begin
          nc = '0;
        end else if (char_code == CH_TAB) begin
          nc = tab_sum & ~((COL_W+1)'(TAB_STOP - 1));
        end else begin
          res.wr_en = 1'b1;
          nc        = {1'b0, bc} + 1'b1;
        end
        // wrap at line end, then scroll past the last row
        if (nc >= (COL_W+1)'(COLUMNS)) begin
          nc = '0;
          nr = nr + 1'b1;
        end
        if (nr >= (ROW_W+1)'(ROWS)) begin
          nr         = (ROW_W+1)'(ROWS - 1);
          res.scroll = 1'b1;
        end
        res.col = nc[COL_W-1:0];
        res.row = nr[ROW_W-1:0];
      end
      CMD_BACK: begin
        if (cur_col != '0) begin
          res.col      = cur_col - 1'b1;
          res.wr_col   = cur_col - 1'b1;
          res.wr_en    = 1'b1;
          res.wr_blank = 1'b1;
        end
      end
      CMD_SET_CUR: begin
        res.col = item_col;
        res.row = item_row;
      end
      CMD_CLEAR: begin
        res.col = '0;
        res.row = '0;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine: screen of character/color cells plus a cursor,
// one command per input item, one result item per command.
// ----------------------------------------------------------------------------
// The screen lives in one single-port RAM of ROWS*COLUMNS cells, organized as
// a ring of rows, so a scroll only moves the top-row pointer and blanks one
// row. Each item goes through accept, execute and deliver; a cell read adds
// a step for the registered RAM output, a put that scrolls adds the blank
// row sweep, and clear adds a sweep of the whole RAM, one cell per cycle
// through the RAM port. After reset the block sweeps the whole RAM to blanks
// with in_tready low; configuration writes are taken at any time. A finished
// result waits in the output register and the next item is accepted
// meanwhile.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst_n,
  // command, char_code, color, col, row (from bit 0), zero padded
  input  logic [IN_W-1:0]    in_tdata,
  input  logic               in_tvalid,
  output logic               in_tready,
  // caret_col, caret_row, cursor_position, cell_char, cell_color, scrolled
  output logic [OUT_W-1:0]   out_tdata,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  logic [COLOR_W-1:0] cfg_data,
  input  logic               cfg_valid,
  output logic               cfg_ready
);

  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_BLANK = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // control
  logic [2:0]         state_r, state_nxt;
  logic [COL_W-1:0]   cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]   cur_row_r, cur_row_nxt;
  logic [ROW_W-1:0]   top_r, top_nxt;
  logic [AW-1:0]      sweep_r, sweep_nxt;
  logic               pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0] dflt_color_r;
  logic [COLOR_W-1:0] sweep_color_r, sweep_color_nxt;

  // payload
  logic [CMD_W-1:0]   cmd_r;
  logic [CHAR_W-1:0]  ch_r;
  logic [COLOR_W-1:0] color_r;
  logic [COL_W-1:0]   icol_r;
  logic [ROW_W-1:0]   irow_r;
  logic [AW-1:0]      base_r, base_nxt;
  logic               scroll_r, scroll_nxt;
  logic [CHAR_W-1:0]  cell_char_r, cell_char_nxt;
  logic [COLOR_W-1:0] cell_color_r, cell_color_nxt;
  logic [OUT_W-1:0]   out_data_r, out_data_nxt;

  // screen RAM
  logic [CELL_W-1:0]  mem [DEPTH];
  logic [CELL_W-1:0]  rd_data_r;
  logic [AW-1:0]      mem_addr;
  logic               mem_we;
  logic [CELL_W-1:0]  mem_wdata;

  logic               in_acc;
  logic [COL_W-1:0]   in_col, in_col_sat;
  logic [ROW_W-1:0]   in_row, in_row_sat;
  step_res_t          res;
  logic [COLOR_W-1:0] eff_color;
  logic [COL_W-1:0]   sel_col;
  logic [ROW_W-1:0]   sel_row;
  logic [ROW_W:0]     phys_sum;
  logic [ROW_W-1:0]   phys_row;
  logic [LIN_W-1:0]   pos_full;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign in_col     = in_tdata[CMD_W+CHAR_W+COLOR_W +: COL_W];
  assign in_row     = in_tdata[CMD_W+CHAR_W+COLOR_W+COL_W +: ROW_W];
  assign in_col_sat = (in_col > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : in_col;
  assign in_row_sat = (in_row > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : in_row;

  tcw_cursor_step #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_step (
    .cmd       (cmd_r),
    .char_code (ch_r),
    .cur_col   (cur_col_r),
    .cur_row   (cur_row_r),
    .item_col  (icol_r),
    .item_row  (irow_r),
    .res       (res)
  );

  assign eff_color = (color_r == '0) ? dflt_color_r : color_r;

  // logical row -> physical row in the ring
  assign sel_col  = (cmd_r == CMD_READ) ? icol_r : res.wr_col;
  assign sel_row  = (cmd_r == CMD_READ) ? irow_r : res.wr_row;
  assign phys_sum = {1'b0, sel_row} + {1'b0, top_r};
  assign phys_row = (phys_sum >= (ROW_W+1)'(ROWS)) ?
                    ROW_W'(phys_sum - (ROW_W+1)'(ROWS)) : phys_sum[ROW_W-1:0];

  assign pos_full = LIN_W'(cur_row_r * COLUMNS) + LIN_W'(cur_col_r);

  always_comb begin
    mem_addr  = AW'(phys_row * COLUMNS) + AW'(sel_col);
    mem_we    = 1'b0;
    mem_wdata = res.wr_blank ? {dflt_color_r, CH_SPACE} : {eff_color, ch_r};
    case (state_r)
      ST_CLEAR: begin
        mem_addr  = sweep_r;
        mem_we    = 1'b1;
        mem_wdata = {sweep_color_r, CH_SPACE};
      end
      ST_BLANK: begin
        mem_addr  = base_r + sweep_r;
        mem_we    = 1'b1;
        mem_wdata = {sweep_color_r, CH_SPACE};
      end
      ST_EXEC: begin
        mem_we = (cmd_r != CMD_READ) && res.wr_en;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_addr];
  end

  always_comb begin
    state_nxt       = state_r;
    cur_col_nxt     = cur_col_r;
    cur_row_nxt     = cur_row_r;
    top_nxt         = top_r;
    sweep_nxt       = sweep_r;
    pend_nxt        = pend_r;
    sweep_color_nxt = sweep_color_r;
    base_nxt        = base_r;
    scroll_nxt      = scroll_r;
    cell_char_nxt   = cell_char_r;
    cell_color_nxt  = cell_color_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;

    case (state_r)
      ST_CLEAR: begin
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == AW'(DEPTH - 1)) begin
          state_nxt = pend_r ? ST_DONE : ST_IDLE;
          pend_nxt  = 1'b0;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cur_col_nxt    = res.col;
        cur_row_nxt    = res.row;
        scroll_nxt     = res.scroll;
        cell_char_nxt  = '0;
        cell_color_nxt = '0;
        sweep_nxt      = '0;
        state_nxt      = ST_DONE;
        if (cmd_r == CMD_CLEAR) begin
          top_nxt         = '0;
          pend_nxt        = 1'b1;
          sweep_color_nxt = dflt_color_r;
          state_nxt       = ST_CLEAR;
        end else if (cmd_r == CMD_READ) begin
          state_nxt = ST_READ;
        end else if (res.scroll) begin
          // old top row becomes the new bottom row
          base_nxt        = AW'(top_r * COLUMNS);
          top_nxt         = (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + 1'b1;
          sweep_color_nxt = dflt_color_r;
          state_nxt       = ST_BLANK;
        end
      end
      ST_BLANK: begin
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == AW'(COLUMNS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: begin
        cell_char_nxt  = rd_data_r[CHAR_W-1:0];
        cell_color_nxt = rd_data_r[CELL_W-1:CHAR_W];
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {scroll_r, cell_color_r, cell_char_r, POS_W'(pos_full),
                           cur_row_r, cur_col_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      cur_col_r     <= '0;
      cur_row_r     <= '0;
      top_r         <= '0;
      sweep_r       <= '0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      dflt_color_r  <= DEFAULT_COLOR_RST;
      sweep_color_r <= DEFAULT_COLOR_RST;
    end else begin
      state_r       <= state_nxt;
      cur_col_r     <= cur_col_nxt;
      cur_row_r     <= cur_row_nxt;
      top_r         <= top_nxt;
      sweep_r       <= sweep_nxt;
      pend_r        <= pend_nxt;
      out_valid_r   <= out_valid_nxt;
      sweep_color_r <= sweep_color_nxt;
      if (cfg_valid && cfg_ready) begin
        dflt_color_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r   <= in_tdata[CMD_W-1:0];
      ch_r    <= in_tdata[CMD_W +: CHAR_W];
      color_r <= in_tdata[CMD_W+CHAR_W +: COLOR_W];
      icol_r  <= in_col_sat;
      irow_r  <= in_row_sat;
    end
    base_r       <= base_nxt;
    scroll_r     <= scroll_nxt;
    cell_char_r  <= cell_char_nxt;
    cell_color_r <= cell_color_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule
